@@ rtl/core/b64d_pkg.sv @@
// shared types, constants and the alphabet lookup for the base64 stream decoder
package b64d_pkg;

	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned SEXTET_W    = 6;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned USER_W      = 3;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [CHAR_W-1:0] PAD_CHAR   = 8'd61;
	localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'd43;
	localparam logic [CHAR_W-1:0] SLASH_CHAR = 8'd47;
	localparam logic [SEXTET_W-1:0] SEXTET_PLUS  = 6'd62;
	localparam logic [SEXTET_W-1:0] SEXTET_SLASH = 6'd63;

	localparam logic [1:0] POS_LAST = 2'd3;

	// one decoded sextet and whether the character belongs to the alphabet or is the pad character
	typedef struct packed {
		logic                valid;
		logic [SEXTET_W-1:0] value;
	} sextet_t;

	// the results caused by one request, compacted, first result in bytes[0]
	typedef struct packed {
		logic [1:0]             cnt;
		logic [2:0][BYTE_W-1:0] bytes;
		logic                   has;
		logic                   bad;
		logic                   done;
	} rec_t;

	function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] ch);
		sextet_t r;
		logic [CHAR_W-1:0] d;
		r.valid = 1'b1;
		r.value = '0;
		d = '0;
		if (ch >= 8'd65 && ch <= 8'd90) begin
			d = ch - 8'd65;
			r.value = d[SEXTET_W-1:0];
		end else if (ch >= 8'd97 && ch <= 8'd122) begin
			d = ch - 8'd71;
			r.value = d[SEXTET_W-1:0];
		end else if (ch >= 8'd48 && ch <= 8'd57) begin
			d = ch + 8'd4;
			r.value = d[SEXTET_W-1:0];
		end else if (ch == PLUS_CHAR) begin
			r.value = SEXTET_PLUS;
		end else if (ch == SLASH_CHAR) begin
			r.value = SEXTET_SLASH;
		end else if (ch == PAD_CHAR) begin
			r.value = '0;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/base64_stream_decoder.sv @@
// top level of the base64 stream decoder
// Takes one base64 character per request on the slave side and decodes with the standard
// alphabet, giving up to three bytes as each group of four characters completes; '=' in the
// third or fourth place drops the matching byte, and a group with a character outside the
// alphabet gives one error result, after which nothing more is given until end of text.
// A request with s_tlast set ends the text and gives a final result with text_done set
// (a marker with has_data clear if the group gave nothing). One character is taken every
// cycle while the record queue has room; results leave at one per cycle from the output
// register while the receiver accepts them, and the QUEUE_DEPTH-entry queue holds the
// records that wait for the back end to step through their bytes.
module base64_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [b64d_pkg::CHAR_W-1:0]   s_tdata,  // text_char
	input  logic                          s_tlast,  // end_of_text
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [b64d_pkg::BYTE_W-1:0]   m_tdata,  // data_byte
	output logic [b64d_pkg::USER_W-1:0]   m_tuser,  // has_data, bad_input, text_done
	output logic                          m_tlast   // run_last
);

	logic           push;
	b64d_pkg::rec_t push_rec;
	logic           q_full;
	logic           pop;
	logic           head_valid;
	b64d_pkg::rec_t head_rec;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_end   (s_tlast),
		.push     (push),
		.push_rec (push_rec),
		.q_full   (q_full)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_user   (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

@@ rtl/core/b64d_front.sv @@
// front end: takes characters, gathers groups and builds result records
module b64d_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [b64d_pkg::CHAR_W-1:0]      in_char,
	input  logic                             in_end,
	output logic                             push,
	output b64d_pkg::rec_t                   push_rec,
	input  logic                             q_full
);

	logic [1:0]                          pos_q;
	logic [2:0][b64d_pkg::SEXTET_W-1:0]  held_q;
	logic                                third_pad_q;
	logic                                grp_inv_q;
	logic                                err_q;

	b64d_pkg::sextet_t sx;
	logic              is_pad;
	logic              accept;
	logic              complete;
	logic              inv;
	logic              emit_err;
	logic              emit_data;
	logic              err_next;
	logic [b64d_pkg::BYTE_W-1:0] d0, d1, d2;
	b64d_pkg::rec_t    rec;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		sx        = b64d_pkg::sextet_of(in_char);
		is_pad    = (in_char == b64d_pkg::PAD_CHAR);
		complete  = (pos_q == b64d_pkg::POS_LAST);
		inv       = grp_inv_q || !sx.valid;
		emit_err  = complete && inv && !err_q;
		emit_data = complete && !inv && !err_q;
		err_next  = err_q || emit_err;
		d0 = {held_q[0], held_q[1][5:4]};
		d1 = {held_q[1][3:0], held_q[2][5:2]};
		d2 = {held_q[2][1:0], sx.value};

		rec = '0;
		if (emit_data) begin
			rec.has      = 1'b1;
			rec.cnt      = 2'd1 + {1'b0, !third_pad_q} + {1'b0, !is_pad};
			rec.bytes[0] = d0;
			rec.bytes[1] = third_pad_q ? d2 : d1;
			rec.bytes[2] = d2;
		end else if (emit_err) begin
			rec.cnt = 2'd1;
			rec.bad = 1'b1;
		end else if (in_end) begin
			rec.cnt = 2'd1;
		end
		if (in_end) begin
			rec.done = 1'b1;
			rec.bad  = rec.bad || err_next;
		end
		push_rec = rec;
		push     = accept && (emit_data || emit_err || in_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			held_q      <= '0;
			third_pad_q <= 1'b0;
			grp_inv_q   <= 1'b0;
			err_q       <= 1'b0;
		end else if (accept) begin
			if (in_end) begin
				pos_q       <= '0;
				held_q      <= '0;
				third_pad_q <= 1'b0;
				grp_inv_q   <= 1'b0;
				err_q       <= 1'b0;
			end else if (complete) begin
				pos_q       <= '0;
				held_q      <= '0;
				third_pad_q <= 1'b0;
				grp_inv_q   <= 1'b0;
				err_q       <= err_next;
			end else begin
				held_q[pos_q] <= sx.value;
				if (pos_q == 2'd2) begin
					third_pad_q <= is_pad;
				end
				grp_inv_q <= inv;
				pos_q     <= pos_q + 2'd1;
			end
		end
	end

endmodule

@@ rtl/core/b64d_queue.sv @@
// short record queue between the front and back ends
module b64d_queue #(
	parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output b64d_pkg::rec_t head_rec
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	b64d_pkg::rec_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head_rec   = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/b64d_back.sv @@
// back end: steps through a record's results into the output register
module b64d_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  b64d_pkg::rec_t                head_rec,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [b64d_pkg::BYTE_W-1:0]   out_data,
	output logic [b64d_pkg::USER_W-1:0]   out_user,
	output logic                          out_last
);

	logic [1:0]                  k_q;
	logic                        valid_q;
	logic [b64d_pkg::BYTE_W-1:0] data_q;
	logic [b64d_pkg::USER_W-1:0] user_q;
	logic                        last_q;
	logic                        load;
	logic                        final_res;
	logic [b64d_pkg::BYTE_W-1:0] sel_byte;

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_user  = user_q;
	assign out_last  = last_q;

	always_comb begin
		load      = head_valid && (!valid_q || out_ready);
		final_res = (k_q == head_rec.cnt - 2'd1);
		pop       = load && final_res;
		case (k_q)
			2'd0:    sel_byte = head_rec.bytes[0];
			2'd1:    sel_byte = head_rec.bytes[1];
			2'd2:    sel_byte = head_rec.bytes[2];
			default: sel_byte = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= sel_byte;
			user_q <= {head_rec.done && final_res, head_rec.bad, head_rec.has};
			last_q <= final_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= final_res ? 2'd0 : k_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
